// File: design/ultrasonic_occupancy_counter_assert.svh
// assertion macros used by the occupancy counter top module
`ifndef ULTRASONIC_OCCUPANCY_COUNTER_ASSERT_SVH
`define ULTRASONIC_OCCUPANCY_COUNTER_ASSERT_SVH

// same-cycle implication, checked outside reset
`define UOC_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked outside reset
`define UOC_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: design/uoc_pkg.sv
// shared types and constants of the ultrasonic occupancy counter
package uoc_pkg;

  localparam int unsigned REM_W = 15;
  localparam int unsigned DIST_W = 11;
  localparam int unsigned THR_W = 8;

  localparam logic [REM_W-1:0] SPEED_NUM = 15'd343;
  localparam logic [REM_W-1:0] SPEED_DEN = 15'd20000;
  localparam logic [DIST_W-1:0] DIST_MAX = 11'd2047;
  localparam logic [THR_W-1:0] THRESHOLD_RESET = 8'd10;
  localparam logic [15:0] OCC_MAX = 16'hFFFF;

  typedef struct packed {
    logic              hit;
    logic [DIST_W-1:0] dist_cm;
  } sns_res_t;

endpackage

// File: design/uoc_sensor.sv
// one echo sensor: pulse timer, running distance and detection
module uoc_sensor import uoc_pkg::*; #(
  parameter int unsigned TIMER_WIDTH = 16
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             adv,
  input  logic             level,
  input  logic [THR_W-1:0] thr,
  output sns_res_t         res
);

  localparam int unsigned DW = TIMER_WIDTH - 5;
  localparam int unsigned CW = (DW > DIST_W) ? DW : DIST_W;
  localparam logic [TIMER_WIDTH-1:0] TMAX = {TIMER_WIDTH{1'b1}};

  logic                   prev_r, prev_nxt;
  logic [TIMER_WIDTH-1:0] ticks_r, ticks_nxt;
  logic [DW-1:0]          dacc_r, dacc_nxt;
  logic [REM_W-1:0]       rem_r, rem_nxt;
  logic [DIST_W-1:0]      dist_r, dist_nxt;
  logic [REM_W-1:0]       rem_sum;
  logic [CW-1:0]          dacc_ext;
  logic [CW-1:0]          thr_ext;
  logic                   hit;

  // distance tracked alongside the timer: each tick adds 343/20000 cm
  assign rem_sum  = rem_r + SPEED_NUM;
  assign dacc_ext = CW'(dacc_r);
  assign thr_ext  = CW'(thr);

  always_comb begin
    prev_nxt  = prev_r;
    ticks_nxt = ticks_r;
    dacc_nxt  = dacc_r;
    rem_nxt   = rem_r;
    dist_nxt  = dist_r;
    hit       = 1'b0;
    if (adv) begin
      if (level && !prev_r) begin
        ticks_nxt = '0;
        dacc_nxt  = '0;
        rem_nxt   = '0;
      end else if (level) begin
        if (ticks_r != TMAX) begin
          ticks_nxt = ticks_r + TIMER_WIDTH'(1);
          if (rem_sum >= SPEED_DEN) begin
            rem_nxt  = rem_sum - SPEED_DEN;
            dacc_nxt = dacc_r + DW'(1);
          end else begin
            rem_nxt = rem_sum;
          end
        end
      end else if (prev_r) begin
        hit = dacc_ext < thr_ext;
        if (dacc_ext > CW'(DIST_MAX)) begin
          dist_nxt = DIST_MAX;
        end else begin
          dist_nxt = dacc_ext[DIST_W-1:0];
        end
      end
      prev_nxt = level;
    end
  end

  assign res.hit     = hit;
  assign res.dist_cm = dist_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prev_r  <= 1'b0;
      ticks_r <= '0;
      dacc_r  <= '0;
      rem_r   <= '0;
      dist_r  <= '0;
    end else begin
      prev_r  <= prev_nxt;
      ticks_r <= ticks_nxt;
      dacc_r  <= dacc_nxt;
      rem_r   <= rem_nxt;
      dist_r  <= dist_nxt;
    end
  end

endmodule

// File: design/ultrasonic_occupancy_counter.sv
// ultrasonic occupancy counter: two echo sensors feeding a people count
//
// in_tdata carries one microsecond tick: bit 0 entry echo level, bit 1 exit echo level.
// each accepted request yields exactly one result on the out_ channel, in order.
// out_tdata: occupancy, entered, exited, entry and exit distance in cm.
// cfg_we with cfg_wdata sets the detection threshold in cm; write it only while idle.
// a taken request is held in the input register, then in the result register that drives out_tvalid.
// throughput: one request per cycle while the receiver takes results, set by the input register
// and result register pair with all per-tick work between them.
// reset (rst_n low, synchronous): timers, distances and count go to zero,
// threshold goes to 10 cm, both channels empty.
// when the receiver stalls the result holds, one more request can wait in the
// input register, then in_tready drops until the result is taken.
`include "ultrasonic_occupancy_counter_assert.svh"

module ultrasonic_occupancy_counter import uoc_pkg::*; #(
  parameter int unsigned TIMER_WIDTH = 16,
  parameter int unsigned COUNT_WIDTH = 16
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_tvalid,
  output logic             in_tready,
  input  logic [7:0]       in_tdata,   // echo_entry, echo_exit, zero pad
  output logic             out_tvalid,
  input  logic             out_tready,
  output logic [39:0]      out_tdata,  // occupancy, entered, exited,
                                       // entry_distance_cm, exit_distance_cm
  input  logic             cfg_we,
  input  logic [THR_W-1:0] cfg_wdata
);

  localparam int unsigned OW = (COUNT_WIDTH > 16) ? COUNT_WIDTH : 16;
  localparam logic [COUNT_WIDTH-1:0] CNT_MAX = {COUNT_WIDTH{1'b1}};

  logic                   in_v_r;
  logic                   lv_entry_r, lv_exit_r;
  logic                   out_v_r;
  logic [39:0]            out_data_r, out_data_nxt;
  logic [THR_W-1:0]       thr_r;
  logic [COUNT_WIDTH-1:0] count_r, count_nxt, count_mid;
  logic                   adv;
  logic                   removed;
  logic [OW-1:0]          count_ext;
  logic [15:0]            occ;
  sns_res_t               ent_res, ext_res;

  assign adv       = in_v_r && (!out_v_r || out_tready);
  assign in_tready = !in_v_r || adv;

  uoc_sensor #(.TIMER_WIDTH(TIMER_WIDTH)) u_entry (
    .clk   (clk),
    .rst_n (rst_n),
    .adv   (adv),
    .level (lv_entry_r),
    .thr   (thr_r),
    .res   (ent_res)
  );

  uoc_sensor #(.TIMER_WIDTH(TIMER_WIDTH)) u_exit (
    .clk   (clk),
    .rst_n (rst_n),
    .adv   (adv),
    .level (lv_exit_r),
    .thr   (thr_r),
    .res   (ext_res)
  );

  // entry applied before exit
  always_comb begin
    count_mid = count_r;
    if (ent_res.hit && count_r != CNT_MAX) begin
      count_mid = count_r + COUNT_WIDTH'(1);
    end
    count_nxt = count_mid;
    removed   = 1'b0;
    if (ext_res.hit && count_mid != '0) begin
      count_nxt = count_mid - COUNT_WIDTH'(1);
      removed   = 1'b1;
    end
    count_ext = OW'(count_nxt);
    if (count_ext > OW'(OCC_MAX)) begin
      occ = OCC_MAX;
    end else begin
      occ = count_ext[15:0];
    end
    out_data_nxt = {ext_res.dist_cm, ent_res.dist_cm, removed, ent_res.hit, occ};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r  <= 1'b0;
      out_v_r <= 1'b0;
      thr_r   <= THRESHOLD_RESET;
      count_r <= '0;
    end else begin
      if (cfg_we) begin
        thr_r <= cfg_wdata;
      end
      if (in_tready) begin
        in_v_r <= in_tvalid;
      end
      if (adv) begin
        out_v_r <= 1'b1;
        count_r <= count_nxt;
      end else if (out_tready) begin
        out_v_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      lv_entry_r <= in_tdata[0];
      lv_exit_r  <= in_tdata[1];
    end
    if (adv) begin
      out_data_r <= out_data_nxt;
    end
  end

  assign out_tvalid = out_v_r;
  assign out_tdata  = out_data_r;

  `UOC_ASSERT_NEXT(a_adv_loads, clk, rst_n, adv, out_v_r, "result not loaded after advance")
  `UOC_ASSERT_IMPL(a_stall_only, clk, rst_n, !in_tready, in_v_r && out_v_r && !out_tready,
    "input stalled without a blocked result")
  `UOC_ASSERT_NEXT(a_count_hold, clk, rst_n, !adv, count_r == $past(count_r),
    "count changed without a request")
  `UOC_ASSERT_NEXT(a_no_event, clk, rst_n, adv && !ent_res.hit && !ext_res.hit,
    count_r == $past(count_r), "count changed without a detection")

endmodule

// File: sim/ultrasonic_occupancy_counter_tb.sv
// testbench for the ultrasonic occupancy counter: directed and random echo ticks checked
// against a cycle-free predictor of the counter
`timescale 1ns / 1ps

module ultrasonic_occupancy_counter_tb;
  import uoc_pkg::*;

  localparam int SNS_ENTRY = 0;
  localparam int SNS_EXIT = 1;

  typedef struct packed {
    logic [DIST_W-1:0] exit_dist;
    logic [DIST_W-1:0] entry_dist;
    logic              exited;
    logic              entered;
    logic [15:0]       occupancy;
  } occ_result_t;

  typedef enum int {RX_OPEN, RX_COIN, RX_SPARSE, RX_MOSTLY} rx_mode_t;

  class occupancy_scoreboard;
    logic [THR_W-1:0]  threshold = THRESHOLD_RESET;
    bit                prev_lvl [2];
    logic [15:0]       pulse_ticks [2];
    logic [DIST_W-1:0] last_dist [2];
    logic [15:0]       people = '0;
    occ_result_t       pending [$];
    int                mismatches = 0;
    int                checked = 0;
    int                requests = 0;
    int                entries = 0;
    int                exits = 0;
    int                refused_exits = 0;
    int                entries_at_full = 0;
    int                saturated_pulses = 0;

    function new();
      foreach (prev_lvl[s]) begin
        prev_lvl[s] = 1'b0;
        pulse_ticks[s] = '0;
        last_dist[s] = '0;
      end
    endfunction

    function bit sense(int s, bit lvl);
      bit          hit;
      int unsigned d;
      hit = 1'b0;
      if (lvl && !prev_lvl[s]) begin
        pulse_ticks[s] = '0;
      end else if (lvl) begin
        if (pulse_ticks[s] != 16'hFFFF) pulse_ticks[s] = pulse_ticks[s] + 16'd1;
      end else if (prev_lvl[s]) begin
        if (pulse_ticks[s] == 16'hFFFF) saturated_pulses++;
        d = (int'(pulse_ticks[s]) * int'(SPEED_NUM)) / int'(SPEED_DEN);
        hit = d < int'(threshold);
        last_dist[s] = (d > int'(DIST_MAX)) ? DIST_MAX : d[DIST_W-1:0];
      end
      prev_lvl[s] = lvl;
      return hit;
    endfunction

    function void note_request(bit entry_lvl, bit exit_lvl);
      bit          ent;
      bit          ext;
      bit          removed;
      occ_result_t r;
      ent = sense(SNS_ENTRY, entry_lvl);
      ext = sense(SNS_EXIT, exit_lvl);
      removed = 1'b0;
      if (ent) begin
        entries++;
        if (people != OCC_MAX) people = people + 16'd1;
        else entries_at_full++;
      end
      if (ext) begin
        if (people != 16'd0) begin
          people = people - 16'd1;
          removed = 1'b1;
          exits++;
        end else begin
          refused_exits++;
        end
      end
      r.occupancy = people;
      r.entered = ent;
      r.exited = removed;
      r.entry_dist = last_dist[SNS_ENTRY];
      r.exit_dist = last_dist[SNS_EXIT];
      pending.push_back(r);
      requests++;
    endfunction

    function void check_result(logic [39:0] data);
      occ_result_t got;
      occ_result_t want;
      got = data;
      checked++;
      if (pending.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("result %0d arrived with nothing expected: %h", checked, data);
        end
        return;
      end
      want = pending.pop_front();
      if (got.occupancy !== want.occupancy || got.entered !== want.entered ||
          got.exited !== want.exited || got.entry_dist !== want.entry_dist ||
          got.exit_dist !== want.exit_dist) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("result %0d: occupancy exp %0d got %0d", checked, want.occupancy,
                   got.occupancy);
          $display("  entered exp %0b got %0b, exited exp %0b got %0b",
                   want.entered, got.entered, want.exited, got.exited);
          $display("  entry_dist exp %0d got %0d, exit_dist exp %0d got %0d",
                   want.entry_dist, got.entry_dist, want.exit_dist, got.exit_dist);
        end
      end
    endfunction
  endclass

  logic             clk = 1'b0;
  logic             rst_n;
  logic             in_tvalid;
  logic             in_tready;
  logic [7:0]       in_tdata;   // echo_entry, echo_exit, zero pad
  logic             out_tvalid;
  logic             out_tready;
  logic [39:0]      out_tdata;  // occupancy, entered, exited,
                                // entry_distance_cm, exit_distance_cm
  logic             cfg_we;
  logic [THR_W-1:0] cfg_wdata;

  occupancy_scoreboard sb = new();

  int rx_hold_req = 0;
  int burst_left = 0;
  int stall_cycles = 0;

  ultrasonic_occupancy_counter DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata)
  );

  always #10 clk = ~clk;

  always @(posedge clk) begin
    if (in_tvalid && !in_tready) stall_cycles++;
  end

  initial begin
    #30_000_000;
    $display("Mismatches found");
    $finish;
  end

  // receiver
  initial begin
    rx_mode_t mode;
    int       mode_left;
    int       step;
    int       hold_left;
    bit       nxt;
    mode = RX_OPEN;
    mode_left = 0;
    step = 0;
    hold_left = 0;
    out_tready <= 1'b0;
    forever begin
      @(posedge clk);
      if (out_tvalid && out_tready) sb.check_result(out_tdata);
      if (hold_left > 0) begin
        hold_left--;
        nxt = 1'b0;
      end else if (rx_hold_req > 0) begin
        hold_left = rx_hold_req;
        rx_hold_req = 0;
        nxt = 1'b0;
      end else begin
        if (mode_left == 0) begin
          mode = rx_mode_t'($urandom_range(0, 3));
          mode_left = $urandom_range(8, 60);
          step = 0;
        end
        mode_left--;
        step++;
        case (mode)
          RX_OPEN:   nxt = 1'b1;
          RX_COIN:   nxt = 1'($urandom_range(0, 1));
          RX_SPARSE: nxt = (step % 4 == 0);
          default:   nxt = (step % 3 != 0);
        endcase
      end
      out_tready <= nxt;
    end
  end

  // valid stays high after a request is taken, so the next call must come in the same step
  task automatic send_tick(bit entry_lvl, bit exit_lvl);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 20);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      if (gap > 0) begin
        in_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    in_tvalid <= 1'b1;
    in_tdata <= {6'b0, exit_lvl, entry_lvl};
    do @(posedge clk); while (!in_tready);
    sb.note_request(entry_lvl, exit_lvl);
  endtask

  task automatic wait_drained();
    in_tvalid <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (3) @(posedge clk);
  endtask

  task automatic write_threshold(logic [THR_W-1:0] value);
    wait_drained();
    cfg_wdata <= value;
    cfg_we <= 1'b1;
    @(posedge clk);
    cfg_we <= 1'b0;
    sb.threshold = value;
  endtask

  task automatic pulse_pair(int len_entry, int len_exit);
    int n;
    n = (len_entry > len_exit) ? len_entry : len_exit;
    for (int i = 0; i < n; i++) send_tick(i < len_entry, i < len_exit);
    send_tick(1'b0, 1'b0);
  endtask

  task automatic run_random(int n_ticks, int hold_at, int pause_at);
    bit lvl [2];
    int left [2];
    int edge_t;
    edge_t = (int'(sb.threshold) * int'(SPEED_DEN) + int'(SPEED_NUM) - 1) / int'(SPEED_NUM);
    foreach (lvl[s]) begin
      lvl[s] = 1'b0;
      left[s] = $urandom_range(0, 5);
    end
    for (int i = 0; i < n_ticks; i++) begin
      if (i == hold_at) rx_hold_req = $urandom_range(200, 400);
      if (i == pause_at) wait_drained();
      foreach (lvl[s]) begin
        if (left[s] == 0) begin
          lvl[s] = !lvl[s];
          if (!lvl[s]) begin
            left[s] = $urandom_range(1, 12);
          end else begin
            case ($urandom_range(0, 3))
              0:       left[s] = $urandom_range(1, 3);
              1:       left[s] = edge_t - 1 + $urandom_range(0, 3);
              2:       left[s] = $urandom_range(1, 200);
              default: left[s] = $urandom_range(1, edge_t + 1);
            endcase
            if (left[s] < 1) left[s] = 1;
          end
        end
        left[s]--;
      end
      // noise and broken pulses
      if ($urandom_range(0, 7) == 0) begin
        send_tick(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
      end else begin
        send_tick(lvl[SNS_ENTRY], lvl[SNS_EXIT]);
      end
    end
  endtask

  initial begin
    logic [1:0] opening_ticks [] = '{
      2'b11, 2'b00, 2'b10, 2'b00, 2'b01, 2'b00,
      2'b01, 2'b01, 2'b01, 2'b00, 2'b11, 2'b11, 2'b10, 2'b00,
      2'b01, 2'b10, 2'b01, 2'b00, 2'b00, 2'b11, 2'b11, 2'b00,
      2'b10, 2'b00, 2'b10, 2'b00, 2'b10, 2'b00
    };
    rst_n <= 1'b0;
    in_tvalid <= 1'b0;
    in_tdata <= '0;
    cfg_we <= 1'b0;
    cfg_wdata <= '0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // first tick after reset, simultaneous edges, exit while empty
    foreach (opening_ticks[i]) send_tick(opening_ticks[i][0], opening_ticks[i][1]);

    // detection boundary at 1 cm and no detection at 0 cm
    write_threshold(8'd1);
    pulse_pair(59, 60);
    pulse_pair(60, 59);
    write_threshold(8'd0);
    pulse_pair(1, 1);
    pulse_pair(3, 2);

    write_threshold(8'd1);
    run_random(150, -1, -1);
    write_threshold(8'd2);
    run_random(120, 60, -1);
    write_threshold(THR_W'($urandom_range(3, 6)));
    run_random(120, -1, 70);

    // one entry, then exits down past zero
    pulse_pair(1, 0);
    for (int i = 0; i < 4; i++) pulse_pair(0, 1);

    wait_drained();
    repeat (4) @(posedge clk);
    $display("%0d ticks, %0d results: %0d entries (%0d at full), %0d exits,",
             sb.requests, sb.checked, sb.entries, sb.entries_at_full, sb.exits);
    $display("%0d exits at zero, %0d saturated pulses, %0d input stall cycles, %0d bad results",
             sb.refused_exits, sb.saturated_pulses, stall_cycles, sb.mismatches);
    if (sb.mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
